@@ rtl/current_sense_calibrated_average_macros.svh @@
// assertion macros for the current sense averager
`ifndef CURRENT_SENSE_CALIBRATED_AVERAGE_MACROS_SVH
`define CURRENT_SENSE_CALIBRATED_AVERAGE_MACROS_SVH

// same-cycle implication, checked on every clock edge outside reset
`define CSCA_ASSERT_NOW(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication, checked on every clock edge outside reset
`define CSCA_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

@@ rtl/csca_pkg.sv @@
// shared types, widths and constants of the current sense averager
`timescale 1ns / 1ps

package csca_pkg;

  localparam int AVG_DEPTH_DEF = 10;

  localparam int RAW_W  = 16;
  localparam int D_W    = 17;
  localparam int D100_W = 24;
  localparam int GAIN_W = 16;
  localparam int INT_W  = 17;
  localparam int V_W    = 21;
  localparam int C_W    = 20;

  localparam int VP_W    = D100_W + GAIN_W + 1;
  localparam int V_SHIFT = 19;
  localparam int VS_W    = VP_W - V_SHIFT + 1;
  localparam int VA_W    = VS_W + 1;
  localparam int V_RND   = 1 << (V_SHIFT - 1);

  localparam int CP_W    = V_W + GAIN_W + 1;
  localparam int C_SHIFT = 14;
  localparam int CS_W    = CP_W - C_SHIFT + 1;
  localparam int CA_W    = CS_W + 1;
  localparam int C_RND   = 1 << (C_SHIFT - 1);

  localparam int V_MIN = -(1 << (V_W - 1));
  localparam int V_MAX = (1 << (V_W - 1)) - 1;
  localparam int C_MAX = (1 << C_W) - 1;

  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  localparam logic [1:0] REG_VGAIN = 2'd0;
  localparam logic [1:0] REG_VINT  = 2'd1;
  localparam logic [1:0] REG_CGAIN = 2'd2;
  localparam logic [1:0] REG_CINT  = 2'd3;

  localparam logic [GAIN_W-1:0] VGAIN_RST = 16'd32276;
  localparam logic [INT_W-1:0]  VINT_RST  = 17'd3142;
  localparam logic [GAIN_W-1:0] CGAIN_RST = 16'd18293;
  localparam logic [INT_W-1:0]  CINT_RST  = 17'h1F1A6;

  typedef struct packed {
    logic [GAIN_W-1:0] vgain;
    logic [INT_W-1:0]  vint;
    logic [GAIN_W-1:0] cgain;
    logic [INT_W-1:0]  cint;
  } cfg_t;

  typedef struct packed {
    logic calib;
    logic load;
    logic scale;
    logic gain;
    logic store;
    logic sum;
    logic dset;
    logic dstep;
    logic cur;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic sum_last;
    logic div_last;
    logic out_free;
  } dp_sts_t;

endpackage

@@ rtl/current_sense_calibrated_average.sv @@
// Current sense averager: offset and gain corrected shunt voltage, moving
// average over the last samples, converted to current in 0.01 mA.
// Input channel (in_valid / in_stall): kind and raw_sample. A calibrate word
// (kind 1) stores the sample as zero offset, empties the ring and produces
// no result. A measure word (kind 0) produces one result.
// Output channel (out_valid / out_stall): current_centi_ma and
// avg_voltage_centi_mv, held in an output register until taken.
// One word is worked on at a time. A measure word goes through the scale,
// gain, store, sum, divide and current steps, then its output step loads
// the result once the output register is free. The ring sum reads the
// filled entries (1 to AVG_DEPTH) one entry a cycle, and the averaging
// divider resolves one quotient bit a cycle, one for each bit of the sum.
// A finished result waiting under out_stall does not block acceptance of the
// next word; that word holds in its last step until the output is free.
// Reset restores the register defaults, zeroes the offset and empties the
// ring. Configuration is written through the apb-style port; the user must
// write it only while idle, as the block itself does not enforce this.
`timescale 1ns / 1ps

module current_sense_calibrated_average #(
  parameter int AVG_DEPTH = csca_pkg::AVG_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              kind,
  input  logic signed [csca_pkg::RAW_W-1:0] raw_sample,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [csca_pkg::C_W-1:0]          current_centi_ma,
  output logic signed [csca_pkg::V_W-1:0]   avg_voltage_centi_mv,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [csca_pkg::ADDR_W-1:0]       paddr,
  input  logic [csca_pkg::DATA_W-1:0]       pwdata,
  output logic [csca_pkg::DATA_W-1:0]       prdata,
  output logic                              pready
);
  import csca_pkg::*;

  cfg_t    cfg;
  dp_cmd_t cmd;
  dp_sts_t sts;

  csca_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  csca_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_kind  (kind),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  csca_dp #(
    .AVG_DEPTH (AVG_DEPTH)
  ) u_dp (
    .clk                  (clk),
    .rst                  (rst),
    .cfg                  (cfg),
    .in_raw               (raw_sample),
    .cmd                  (cmd),
    .sts                  (sts),
    .out_stall            (out_stall),
    .out_valid            (out_valid),
    .current_centi_ma     (current_centi_ma),
    .avg_voltage_centi_mv (avg_voltage_centi_mv)
  );

endmodule

@@ rtl/csca_regs.sv @@
// configuration register file behind the apb-style port
`timescale 1ns / 1ps

module csca_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [csca_pkg::ADDR_W-1:0] paddr,
  input  logic [csca_pkg::DATA_W-1:0] pwdata,
  output logic [csca_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output csca_pkg::cfg_t             cfg
);
  import csca_pkg::*;

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.vgain <= VGAIN_RST;
      cfg.vint  <= VINT_RST;
      cfg.cgain <= CGAIN_RST;
      cfg.cint  <= CINT_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_VGAIN: cfg.vgain <= pwdata[GAIN_W-1:0];
        REG_VINT:  cfg.vint  <= pwdata[INT_W-1:0];
        REG_CGAIN: cfg.cgain <= pwdata[GAIN_W-1:0];
        REG_CINT:  cfg.cint  <= pwdata[INT_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_VGAIN: prdata = DATA_W'(cfg.vgain);
      REG_VINT:  prdata = DATA_W'($signed(cfg.vint));
      REG_CGAIN: prdata = DATA_W'(cfg.cgain);
      REG_CINT:  prdata = DATA_W'($signed(cfg.cint));
    endcase
  end

endmodule

@@ rtl/csca_ctrl.sv @@
// sequencing state machine of the current sense averager
`timescale 1ns / 1ps
`include "current_sense_calibrated_average_macros.svh"

module csca_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_kind,
  output logic                in_stall,
  input  csca_pkg::dp_sts_t   sts,
  output csca_pkg::dp_cmd_t   cmd
);
  import csca_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SCALE = 4'd1;
  localparam logic [3:0] S_GAIN  = 4'd2;
  localparam logic [3:0] S_STORE = 4'd3;
  localparam logic [3:0] S_SUM   = 4'd4;
  localparam logic [3:0] S_DSET  = 4'd5;
  localparam logic [3:0] S_DIV   = 4'd6;
  localparam logic [3:0] S_CUR   = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;

  logic [3:0] state, state_next;
  logic       accept;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        cmd.calib = accept && in_kind;
        cmd.load  = accept && !in_kind;
        if (accept && !in_kind) state_next = S_SCALE;
      end
      S_SCALE: begin
        cmd.scale  = 1'b1;
        state_next = S_GAIN;
      end
      S_GAIN: begin
        cmd.gain   = 1'b1;
        state_next = S_STORE;
      end
      S_STORE: begin
        cmd.store  = 1'b1;
        state_next = S_SUM;
      end
      S_SUM: begin
        cmd.sum = 1'b1;
        if (sts.sum_last) state_next = S_DSET;
      end
      S_DSET: begin
        cmd.dset   = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.dstep = 1'b1;
        if (sts.div_last) state_next = S_CUR;
      end
      S_CUR: begin
        cmd.cur    = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        cmd.out_load = sts.out_free;
        if (sts.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `CSCA_ASSERT_NEXT(a_calib_stays_idle, in_valid && !in_stall && in_kind, state == S_IDLE, "calibrate word left idle")
  `CSCA_ASSERT_NEXT(a_measure_starts, in_valid && !in_stall && !in_kind, state == S_SCALE, "measure word did not start")
  `CSCA_ASSERT_NOW(a_load_when_free, cmd.out_load, sts.out_free, "result loaded over a held word")

endmodule

@@ rtl/csca_dp.sv @@
// datapath: offset and gain correction, sample ring, averaging divider, current scaling
`timescale 1ns / 1ps
`include "current_sense_calibrated_average_macros.svh"

module csca_dp #(
  parameter int AVG_DEPTH = csca_pkg::AVG_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  csca_pkg::cfg_t                   cfg,
  input  logic signed [csca_pkg::RAW_W-1:0] in_raw,
  input  csca_pkg::dp_cmd_t                cmd,
  output csca_pkg::dp_sts_t                sts,
  input  logic                             out_stall,
  output logic                             out_valid,
  output logic [csca_pkg::C_W-1:0]         current_centi_ma,
  output logic signed [csca_pkg::V_W-1:0]  avg_voltage_centi_mv
);
  import csca_pkg::*;

  localparam int SLOT_W = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
  localparam int CNT_W  = $clog2(AVG_DEPTH + 1);
  localparam int SUM_W  = V_W + CNT_W;
  localparam int DCNT_W = $clog2(SUM_W);

  logic signed [RAW_W-1:0]  zero_offset;
  logic signed [RAW_W-1:0]  raw_q;
  logic signed [D100_W-1:0] d100;
  logic signed [VP_W-1:0]   vprod;
  logic signed [V_W-1:0]    ring [AVG_DEPTH];
  logic [SLOT_W-1:0]        write_slot;
  logic [SLOT_W-1:0]        sum_idx;
  logic [CNT_W-1:0]         fill_count;
  logic signed [SUM_W-1:0]  acc;
  logic                     div_neg;
  logic [SUM_W-1:0]         quo;
  logic [CNT_W:0]           rem;
  logic [DCNT_W-1:0]        dcnt;
  logic signed [V_W-1:0]    avg_q;
  logic signed [CP_W-1:0]   cprod;

  logic signed [D_W-1:0]    d_diff;
  logic signed [GAIN_W:0]   vgain_s;
  logic signed [GAIN_W:0]   cgain_s;
  logic signed [VP_W:0]     vrnd;
  logic signed [VS_W-1:0]   vsh;
  logic signed [VA_W-1:0]   vsum;
  logic signed [V_W-1:0]    vsat;
  logic [SUM_W-1:0]         acc_mag;
  logic [CNT_W:0]           rem_sh;
  logic [CNT_W:0]           divisor;
  logic                     rem_ge;
  logic [V_W-1:0]           quo_v;
  logic signed [V_W-1:0]    avg_w;
  logic signed [CP_W:0]     crnd;
  logic signed [CS_W-1:0]   csh;
  logic signed [CA_W-1:0]   cval;
  logic [C_W-1:0]           cclamp;

  assign vgain_s = $signed({1'b0, cfg.vgain});
  assign cgain_s = $signed({1'b0, cfg.cgain});
  assign d_diff  = D_W'(raw_q) - D_W'(zero_offset);

  // voltage rounding, floor shift, intercept and saturation
  assign vrnd = (VP_W + 1)'(vprod) + (VP_W + 1)'(V_RND);
  assign vsh  = vrnd[VP_W:V_SHIFT];
  assign vsum = VA_W'(vsh) + VA_W'($signed(cfg.vint));

  always_comb begin
    if (vsum < VA_W'(V_MIN)) begin
      vsat = V_W'(V_MIN);
    end else if (vsum > VA_W'(V_MAX)) begin
      vsat = V_W'(V_MAX);
    end else begin
      vsat = vsum[V_W-1:0];
    end
  end

  // restoring divider on the magnitude of the ring sum
  assign acc_mag = acc[SUM_W-1] ? SUM_W'(-acc) : SUM_W'(acc);
  assign rem_sh  = {rem[CNT_W-1:0], quo[SUM_W-1]};
  assign divisor = {1'b0, fill_count};
  assign rem_ge  = (rem_sh >= divisor);
  assign quo_v   = quo[V_W-1:0];
  assign avg_w   = div_neg ? -$signed(quo_v) : $signed(quo_v);

  // current rounding, floor shift, intercept and clamp
  assign crnd = (CP_W + 1)'(cprod) + (CP_W + 1)'(C_RND);
  assign csh  = crnd[CP_W:C_SHIFT];
  assign cval = CA_W'(csh) + CA_W'($signed(cfg.cint));

  always_comb begin
    if (cval < CA_W'(0)) begin
      cclamp = '0;
    end else if (cval > CA_W'(C_MAX)) begin
      cclamp = C_W'(C_MAX);
    end else begin
      cclamp = cval[C_W-1:0];
    end
  end

  assign sts.sum_last = (CNT_W'(sum_idx) + CNT_W'(1)) == fill_count;
  assign sts.div_last = (dcnt == DCNT_W'(SUM_W - 1));
  assign sts.out_free = !out_valid || !out_stall;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      zero_offset <= '0;
      write_slot  <= '0;
      fill_count  <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cmd.calib) begin
        zero_offset <= in_raw;
        write_slot  <= '0;
        fill_count  <= '0;
      end else if (cmd.store) begin
        write_slot <= (write_slot == SLOT_W'(AVG_DEPTH - 1)) ? '0
                                                              : write_slot + SLOT_W'(1);
        if (fill_count != CNT_W'(AVG_DEPTH)) fill_count <= fill_count + CNT_W'(1);
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load) raw_q <= in_raw;
    if (cmd.scale) d100 <= D100_W'(d_diff) * D100_W'(100);
    if (cmd.gain) vprod <= d100 * vgain_s;
    if (cmd.store) begin
      ring[write_slot] <= vsat;
      acc              <= '0;
      sum_idx          <= '0;
    end
    if (cmd.sum) begin
      acc     <= acc + SUM_W'(ring[sum_idx]);
      sum_idx <= sum_idx + SLOT_W'(1);
    end
    if (cmd.dset) begin
      div_neg <= acc[SUM_W-1];
      quo     <= acc_mag;
      rem     <= '0;
      dcnt    <= '0;
    end
    if (cmd.dstep) begin
      rem  <= rem_ge ? rem_sh - divisor : rem_sh;
      quo  <= {quo[SUM_W-2:0], rem_ge};
      dcnt <= dcnt + DCNT_W'(1);
    end
    if (cmd.cur) begin
      avg_q <= avg_w;
      cprod <= avg_w * cgain_s;
    end
    if (cmd.out_load) begin
      current_centi_ma     <= cclamp;
      avg_voltage_centi_mv <= avg_q;
    end
  end

  `CSCA_ASSERT_NOW(a_fill_bound, 1'b1, fill_count <= CNT_W'(AVG_DEPTH), "fill count above depth")
  `CSCA_ASSERT_NOW(a_slot_bound, 1'b1, write_slot <= SLOT_W'(AVG_DEPTH - 1), "write slot past ring")
  `CSCA_ASSERT_NEXT(a_calib_empties, cmd.calib, fill_count == '0 && write_slot == '0, "ring not emptied")

endmodule

@@ tb/sv/current_sense_calibrated_average_tb.sv @@
// testbench for the current sense averager: directed and random words checked against a predictor
`timescale 1ns / 1ps

module current_sense_calibrated_average_tb;
  import csca_pkg::*;

  localparam int RING_DEPTH    = AVG_DEPTH_DEF;
  localparam int IDLE_LIMIT    = 4000;
  localparam int SETTLE_CYCLES = 64;
  localparam int RANDOM_PHASES = 15;
  localparam int PHASE_WORDS   = 110;
  localparam int PRINT_CAP     = 40;

  localparam logic KIND_MEASURE   = 1'b0;
  localparam logic KIND_CALIBRATE = 1'b1;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_RUNS} stall_mode_e;
  typedef enum int {GAPS_NONE, GAPS_SHORT, GAPS_LONG} gap_mode_e;

  typedef struct packed {
    logic [C_W-1:0]        current;
    logic signed [V_W-1:0] voltage;
  } reading_t;

  logic                     clk;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic                     kind = KIND_MEASURE;
  logic signed [RAW_W-1:0]  raw_sample = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [C_W-1:0]           current_centi_ma;
  logic signed [V_W-1:0]    avg_voltage_centi_mv;
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [ADDR_W-1:0]        paddr = '0;
  logic [DATA_W-1:0]        pwdata = '0;
  logic [DATA_W-1:0]        prdata;
  logic                     pready;

  // predictor state
  logic [GAIN_W-1:0]        vgain_m = VGAIN_RST;
  logic signed [INT_W-1:0]  vint_m = VINT_RST;
  logic [GAIN_W-1:0]        cgain_m = CGAIN_RST;
  logic signed [INT_W-1:0]  cint_m = CINT_RST;
  logic signed [RAW_W-1:0]  offset_m = '0;
  longint                   ring_m [RING_DEPTH] = '{default: 0};
  int                       slot_m = 0;
  int                       fill_m = 0;

  reading_t                 pending_readings [$];

  int          mismatches = 0;
  int          results_seen = 0;
  int          measures_sent = 0;
  int          calibrations_sent = 0;
  int          reg_writes = 0;
  int          burst_left = 0;
  gap_mode_e   gap_mode = GAPS_SHORT;
  stall_mode_e stall_mode = STALL_NONE;
  int          stall_left = 0;
  int          idle_cycles = 0;
  bit          watch_on = 1'b0;

  current_sense_calibrated_average #(
    .AVG_DEPTH(RING_DEPTH)
  ) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .kind(kind),
    .raw_sample(raw_sample),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .current_centi_ma(current_centi_ma),
    .avg_voltage_centi_mv(avg_voltage_centi_mv),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic void predict_reading(input logic calib, input logic signed [RAW_W-1:0] s);
    longint diff, volt, total, mean, amps;
    reading_t r;
    if (calib == KIND_CALIBRATE) begin
      offset_m = s;
      foreach (ring_m[i]) ring_m[i] = 0;
      slot_m = 0;
      fill_m = 0;
    end else begin
      diff = longint'(s) - longint'(offset_m);
      volt = ((diff * 100 * longint'(vgain_m)) + (longint'(1) << 18)) >>> 19;
      volt = volt + longint'(vint_m);
      if (volt < V_MIN) volt = V_MIN;
      if (volt > V_MAX) volt = V_MAX;
      ring_m[slot_m] = volt;
      slot_m = (slot_m + 1) % RING_DEPTH;
      if (fill_m < RING_DEPTH) fill_m++;
      total = 0;
      for (int i = 0; i < fill_m; i++) total += ring_m[i];
      mean = total / longint'(fill_m);
      amps = ((mean * longint'(cgain_m)) + (longint'(1) << 13)) >>> 14;
      amps = amps + longint'(cint_m);
      if (amps < 0) amps = 0;
      if (amps > C_MAX) amps = C_MAX;
      r.current = amps[C_W-1:0];
      r.voltage = mean[V_W-1:0];
      pending_readings.push_back(r);
    end
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (mismatches < PRINT_CAP)
      $display("mismatch at result %0d, %s: got %0d, expected %0d", results_seen, what, got, want);
    mismatches++;
  endtask

  // one word on the input channel, with bursts and gaps around it
  task automatic send_word(input logic k, input logic signed [RAW_W-1:0] s);
    int gap;
    in_valid <= 1'b1;
    kind <= k;
    raw_sample <= s;
    do @(posedge clk); while (in_stall);
    predict_reading(k, s);
    if (k == KIND_CALIBRATE) calibrations_sent++;
    else measures_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 24);
      case (gap_mode)
        GAPS_NONE:  gap = 0;
        GAPS_SHORT: gap = $urandom_range(1, 4);
        default:    gap = $urandom_range(1, 60);
      endcase
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // drop valid, wait for all results, then let a calibrate word finish
  task automatic settle_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [DATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_VGAIN: vgain_m = data[GAIN_W-1:0];
      REG_VINT:  vint_m = data[INT_W-1:0];
      REG_CGAIN: cgain_m = data[GAIN_W-1:0];
      REG_CINT:  cint_m = data[INT_W-1:0];
      default: ;
    endcase
    reg_writes++;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // extreme or random field value, random bits above the field
  function automatic logic [DATA_W-1:0] pick_setting(input int bits, input bit is_signed);
    logic [DATA_W-1:0] low, word;
    int choice;
    choice = $urandom_range(0, 3);
    if (choice == 0) low = is_signed ? (32'd1 << (bits - 1)) : 32'd0;
    else if (choice == 1) low = is_signed ? ((32'd1 << (bits - 1)) - 1) : ((32'd1 << bits) - 1);
    else low = $urandom() & ((32'd1 << bits) - 1);
    word = ($urandom() << bits) | low;
    return word;
  endfunction

  function automatic logic signed [RAW_W-1:0] pick_sample();
    int pick, t;
    pick = $urandom_range(0, 9);
    if (pick < 4) t = $urandom_range(0, 65535);
    else if (pick < 8) t = int'(offset_m) + int'($urandom_range(0, 800)) - 400;
    else if (pick == 8) t = 32767;
    else t = -32768;
    return t[RAW_W-1:0];
  endfunction

  task automatic test_default_scaling();
    send_word(KIND_MEASURE, 16'sd0);
    send_word(KIND_MEASURE, 16'sh7fff);
    send_word(KIND_MEASURE, 16'sh8000);
    send_word(KIND_MEASURE, -16'sd1);
  endtask

  task automatic test_zero_calibration();
    send_word(KIND_CALIBRATE, 16'sh7fff);
    send_word(KIND_MEASURE, 16'sh8000);
    send_word(KIND_CALIBRATE, 16'sh8000);
    send_word(KIND_MEASURE, 16'sh7fff);
    send_word(KIND_CALIBRATE, 16'sd0);
  endtask

  // more words than the ring holds so the oldest slot gets replaced
  task automatic test_ring_wraparound();
    for (int i = 0; i < RING_DEPTH + 1; i++)
      send_word(KIND_MEASURE, (i % 2) ? 16'sh7fff : 16'sh5555 ^ 16'(i));
  endtask

  task automatic test_output_limits();
    settle_idle();
    write_reg(REG_VGAIN, 32'h0000_ffff);
    write_reg(REG_VINT, 32'h0000_ffff);
    write_reg(REG_CGAIN, 32'h0000_ffff);
    write_reg(REG_CINT, 32'h0000_ffff);
    send_word(KIND_CALIBRATE, 16'sh8000);
    send_word(KIND_MEASURE, 16'sh7fff);
    settle_idle();
    write_reg(REG_VINT, 32'hffff_0000);
    write_reg(REG_CINT, 32'hfffe_0000);
    send_word(KIND_CALIBRATE, 16'sh7fff);
    send_word(KIND_MEASURE, 16'sh8000);
  endtask

  task automatic test_random_traffic();
    logic k;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      settle_idle();
      if ($urandom_range(0, 4) == 0) begin
        write_reg(REG_VGAIN, 32'(VGAIN_RST));
        write_reg(REG_VINT, 32'(VINT_RST));
        write_reg(REG_CGAIN, 32'(CGAIN_RST));
        write_reg(REG_CINT, 32'(CINT_RST));
      end else begin
        write_reg(REG_VGAIN, pick_setting(GAIN_W, 1'b0));
        write_reg(REG_VINT, pick_setting(INT_W, 1'b1));
        write_reg(REG_CGAIN, pick_setting(GAIN_W, 1'b0));
        write_reg(REG_CINT, pick_setting(INT_W, 1'b1));
      end
      gap_mode = gap_mode_e'($urandom_range(0, 2));
      burst_left = 0;
      send_word(KIND_CALIBRATE, pick_sample());
      for (int n = 0; n < PHASE_WORDS; n++) begin
        k = ($urandom_range(0, 19) == 0) ? KIND_CALIBRATE : KIND_MEASURE;
        send_word(k, pick_sample());
      end
    end
  endtask

  // receiver stall pattern, switching among four randomly chosen styles
  always @(posedge clk) begin : stall_pattern
    logic stall_next;
    if (stall_left == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 3));
      stall_left = $urandom_range(40, 300);
    end
    stall_left--;
    case (stall_mode)
      STALL_NONE:  stall_next = 1'b0;
      STALL_LIGHT: stall_next = ($urandom_range(0, 3) == 0);
      STALL_HEAVY: stall_next = ($urandom_range(0, 3) != 0);
      default:     stall_next = ((stall_left % 32) < 12);
    endcase
    out_stall <= stall_next;
  end

  always @(posedge clk) begin : check_output
    reading_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_readings.size() == 0) begin
        report_mismatch("word with nothing pending, current", longint'(current_centi_ma), 0);
      end else begin
        want = pending_readings.pop_front();
        if (current_centi_ma !== want.current)
          report_mismatch("current_centi_ma", longint'(current_centi_ma), longint'(want.current));
        if (avg_voltage_centi_mv !== want.voltage)
          report_mismatch("avg_voltage_centi_mv", longint'(avg_voltage_centi_mv),
                          longint'(want.voltage));
      end
      results_seen++;
    end
  end

  always @(posedge clk) begin : watchdog
    if (watch_on) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
          (psel && penable && pwrite && pready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("stalled for %0d cycles with %0d results pending", idle_cycles,
                   pending_readings.size());
          $display("current_sense_calibrated_average_tb: done, errors");
          $finish;
        end
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    watch_on = 1'b1;
    test_default_scaling();
    test_zero_calibration();
    test_ring_wraparound();
    test_output_limits();
    test_random_traffic();
    settle_idle();
    watch_on = 1'b0;
    $display("covered %0d measure and %0d calibrate words, %0d register writes",
             measures_sent, calibrations_sent, reg_writes);
    $display("compared %0d results, %0d mismatches, %0d left pending",
             results_seen, mismatches, pending_readings.size());
    if (mismatches == 0 && pending_readings.size() == 0) begin
      $display("current_sense_calibrated_average_tb: done, clean");
    end else begin
      $display("current_sense_calibrated_average_tb: done, errors");
    end
    $finish;
  end

endmodule
